// ===== rtl/core/sdf_pkg.sv =====
// Shared types and constants for the stepper reply deframer.
// Command codes, frame lengths, reply kinds and the per-byte result record.
// No dependencies.
`timescale 1ns / 1ps

package sdf_pkg;

  // Command codes carried in byte 1 of a reply frame
  localparam logic [7:0] CODE_VEL  = 8'h35;
  localparam logic [7:0] CODE_POS  = 8'h36;
  localparam logic [7:0] CODE_FLAG = 8'h3A;
  localparam logic [7:0] CODE_IO   = 8'h3D;

  // Terminator byte of a well-formed frame
  localparam logic [7:0] FRAME_END = 8'h6B;

  // Frame lengths in bytes; zero marks an unknown code
  localparam logic [3:0] LEN_NONE = 4'd0;
  localparam logic [3:0] LEN_VEL  = 4'd6;
  localparam logic [3:0] LEN_POS  = 4'd8;
  localparam logic [3:0] LEN_FLAG = 4'd4;
  localparam logic [3:0] LEN_IO   = 4'd4;

  // Reply kinds as reported on the result
  localparam logic [1:0] KIND_VEL  = 2'd0;
  localparam logic [1:0] KIND_POS  = 2'd1;
  localparam logic [1:0] KIND_FLAG = 2'd2;
  localparam logic [1:0] KIND_IO   = 2'd3;

  // Bytes held for the decode: frame positions 0 through 6
  localparam int unsigned HELD_BYTES = 7;

  typedef logic [HELD_BYTES-1:0][7:0] held_bytes_t;

  // Result of one received byte, less the pending count
  typedef struct packed {
    logic              done;
    logic              ok;
    logic              dropped;
    logic [7:0]        addr;
    logic [1:0]        kind;
    logic signed [31:0] value;
  } sdf_result_t;

  // Frame length for a command code
  function automatic logic [3:0] frame_len(input logic [7:0] code);
    logic [3:0] len;
    unique case (code)
      CODE_VEL:  len = LEN_VEL;
      CODE_POS:  len = LEN_POS;
      CODE_FLAG: len = LEN_FLAG;
      CODE_IO:   len = LEN_IO;
      default:   len = LEN_NONE;
    endcase
    return len;
  endfunction

  // Reply kind for a known command code
  function automatic logic [1:0] reply_kind_of(input logic [7:0] code);
    logic [1:0] kind;
    unique case (code)
      CODE_VEL:  kind = KIND_VEL;
      CODE_POS:  kind = KIND_POS;
      CODE_FLAG: kind = KIND_FLAG;
      default:   kind = KIND_IO;
    endcase
    return kind;
  endfunction

endpackage

// ===== rtl/core/sdf_decode.sv =====
// Combinational frame decode for one received byte.
// Uses sdf_pkg for codes, lengths and the result record.
`timescale 1ns / 1ps

module sdf_decode #(
  parameter int unsigned CNT_W = 4
) (
  input  logic [7:0]          rx_byte,
  input  logic [CNT_W-1:0]    count_cur,
  input  sdf_pkg::held_bytes_t held,
  output sdf_pkg::sdf_result_t result,
  output logic [CNT_W-1:0]    count_next
);
  import sdf_pkg::*;

  logic [CNT_W-1:0] count_inc;
  logic [7:0]       code;
  logic [3:0]       len;
  logic             neg;
  logic [31:0]      mag;
  logic [31:0]      mag_signed;

  // Count after storing this byte; code is this byte when it lands in slot 1
  assign count_inc = count_cur + CNT_W'(1);
  assign code      = (count_cur == CNT_W'(1)) ? rx_byte : held[1];
  assign len       = frame_len(code);
  assign neg       = (held[2] != 8'd0);

  // Magnitude by reply kind, then optional negation modulo 2^32
  always_comb begin
    unique case (reply_kind_of(code))
      KIND_VEL: mag = {16'd0, held[3], held[4]};
      KIND_POS: mag = {held[3], held[4], held[5], held[6]};
      default:  mag = {24'd0, held[2]};
    endcase
  end

  always_comb begin
    if (neg && (reply_kind_of(code) == KIND_VEL || reply_kind_of(code) == KIND_POS)) begin
      mag_signed = 32'd0 - mag;
    end else begin
      mag_signed = mag;
    end
  end

  // Frame completion, drop and count update
  always_comb begin
    result     = '0;
    count_next = count_inc;
    if (count_inc >= CNT_W'(2)) begin
      if (len == LEN_NONE) begin
        result.dropped = 1'b1;
        count_next     = '0;
      end else if (count_inc >= CNT_W'(len)) begin
        result.done = 1'b1;
        result.ok   = (rx_byte == FRAME_END);
        result.addr = held[0];
        result.kind = reply_kind_of(code);
        if (rx_byte == FRAME_END) begin
          result.value = signed'(mag_signed);
        end
        count_next = '0;
      end
    end
  end

endmodule

// ===== rtl/core/stepper_reply_deframer.sv =====
// Stepper reply deframer top level: input register, frame store, result register.
// Depends on sdf_pkg and sdf_decode.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------------
//   in      | in_valid / in_stall | rx_byte
//   out     | out_valid/out_stall | frame_done frame_ok frame_dropped responder_addr
//           |                     | reply_kind reply_value pending_bytes
//
// One item in and one item out per cycle while no stall holds the flow; an item
// goes through the input register, then the decode into the result register.
// The decode of a byte reads the frame store and byte count as left by the
// previous byte. Reset clears the count and both valid flags; the frame store
// is not cleared. A stalled result holds and backs up the input register.
`timescale 1ns / 1ps

module stepper_reply_deframer #(
  parameter int unsigned MAX_FRAME_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               frame_done,
  output logic               frame_ok,
  output logic               frame_dropped,
  output logic [7:0]         responder_addr,
  output logic [1:0]         reply_kind,
  output logic signed [31:0] reply_value,
  output logic [2:0]         pending_bytes
);
  import sdf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_FRAME_BYTES);

  logic             in_held_valid;
  logic [7:0]       in_byte;
  logic [7:0]       frame_bytes [MAX_FRAME_BYTES];
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] count_cur;
  logic [CNT_W-1:0] byte_count_next;
  held_bytes_t      held;
  sdf_result_t      result;
  logic             out_free;
  logic             advance;

  // Result slot is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign advance  = in_held_valid && out_free;
  assign in_stall = in_held_valid && !out_free;

  // Wrap a full buffer before storing
  assign count_cur = (byte_count >= CNT_W'(MAX_FRAME_BYTES)) ? '0 : byte_count;

  // Fixed taps of the frame store used by the decode
  always_comb begin
    for (int i = 0; i < HELD_BYTES; i++) begin
      held[i] = frame_bytes[i];
    end
  end

  sdf_decode #(
    .CNT_W(CNT_W)
  ) u_decode (
    .rx_byte    (in_byte),
    .count_cur  (count_cur),
    .held       (held),
    .result     (result),
    .count_next (byte_count_next)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_held_valid <= 1'b0;
    end else if (!in_stall) begin
      in_held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte <= rx_byte;
    end
  end

  // Frame store and byte count advance with each decoded item
  always_ff @(posedge clk) begin
    if (advance) begin
      frame_bytes[count_cur[IDX_W-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (advance) begin
      byte_count <= byte_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_done     <= result.done;
      frame_ok       <= result.ok;
      frame_dropped  <= result.dropped;
      responder_addr <= result.addr;
      reply_kind     <= result.kind;
      reply_value    <= result.value;
      pending_bytes  <= byte_count_next[2:0];
    end
  end

endmodule

// ===== rtl/core/sdf_checker.sv =====
// Port-level checks for the stepper reply deframer, bound to the top level.
// Sees the top-level ports only; no package dependency.
`timescale 1ns / 1ps

module sdf_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic               frame_done,
  input logic               frame_ok,
  input logic               frame_dropped,
  input logic [7:0]         responder_addr,
  input logic [1:0]         reply_kind,
  input logic signed [31:0] reply_value,
  input logic [2:0]         pending_bytes
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(reply_value) && $stable(pending_bytes))
    else $error("stalled result changed");

  // Never complete and drop on the same byte
  a_done_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_done && frame_dropped))
    else $error("frame both done and dropped");

  // A good frame is a completed frame
  a_ok_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_ok |-> frame_done)
    else $error("frame_ok without frame_done");

  // Completion or drop empties the buffer
  a_pending_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_done || frame_dropped) |-> pending_bytes == 3'd0)
    else $error("bytes pending after frame end");

  // No decoded data without a completed, terminated frame
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_ok |-> reply_value == 32'sd0
      && (frame_done || (responder_addr == 8'd0 && reply_kind == 2'd0)))
    else $error("decoded fields set without a good frame");

endmodule

bind stepper_reply_deframer sdf_checker u_sdf_checker (.*);

// ===== bench/testbench.sv =====
// Testbench for stepper_reply_deframer: drives reply bytes, predicts each result, checks it.
// Depends on sdf_pkg and the deframer RTL.
`timescale 1ns / 1ps

module testbench;
  import sdf_pkg::*;

  localparam int unsigned FRAME_DEPTH  = 8;
  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned PHASE_BYTES  = 530;
  localparam int unsigned LONG_HOLD    = 60;
  localparam int unsigned LIMIT_CYCLES = 200_000;

  // Expected result of one byte, pending count included
  typedef struct packed {
    sdf_result_t res;
    logic [2:0]  pending;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               frame_done;
  logic               frame_ok;
  logic               frame_dropped;
  logic [7:0]         responder_addr;
  logic [1:0]         reply_kind;
  logic signed [31:0] reply_value;
  logic [2:0]         pending_bytes;

  // Predictor state
  logic [7:0]  frame_store [FRAME_DEPTH];
  int unsigned held_count = 0;

  logic [7:0]  pending_rx [$];
  reply_t      expected_replies [$];
  int unsigned queued_total = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned phase = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  stepper_reply_deframer #(
    .MAX_FRAME_BYTES(FRAME_DEPTH)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_done    (frame_done),
    .frame_ok      (frame_ok),
    .frame_dropped (frame_dropped),
    .responder_addr(responder_addr),
    .reply_kind    (reply_kind),
    .reply_value   (reply_value),
    .pending_bytes (pending_bytes)
  );

  always #(CLK_HALF) clk = ~clk;

  // Store one byte into the frame and work out the result it causes
  function automatic reply_t predict_reply(input logic [7:0] b);
    reply_t      r;
    logic [7:0]  code;
    logic [3:0]  len;
    logic [31:0] mag;
    r = '0;
    if (held_count >= FRAME_DEPTH) held_count = 0;
    frame_store[held_count] = b;
    held_count++;
    if (held_count >= 2) begin
      code = frame_store[1];
      case (code)
        CODE_VEL:  len = LEN_VEL;
        CODE_POS:  len = LEN_POS;
        CODE_FLAG: len = LEN_FLAG;
        CODE_IO:   len = LEN_IO;
        default:   len = LEN_NONE;
      endcase
      if (len == LEN_NONE) begin
        r.res.dropped = 1'b1;
        held_count = 0;
      end else if (held_count >= len) begin
        r.res.done = 1'b1;
        r.res.addr = frame_store[0];
        r.res.ok   = (frame_store[len - 1] == FRAME_END);
        case (code)
          CODE_VEL:  r.res.kind = KIND_VEL;
          CODE_POS:  r.res.kind = KIND_POS;
          CODE_FLAG: r.res.kind = KIND_FLAG;
          default:   r.res.kind = KIND_IO;
        endcase
        if (r.res.ok) begin
          case (r.res.kind)
            KIND_VEL: mag = {16'h0000, frame_store[3], frame_store[4]};
            KIND_POS: mag = {frame_store[3], frame_store[4], frame_store[5], frame_store[6]};
            default:  mag = {24'h000000, frame_store[2]};
          endcase
          // Sign byte negates velocity and position, modulo 2^32
          if ((r.res.kind == KIND_VEL || r.res.kind == KIND_POS) && frame_store[2] != 8'h00)
            mag = 32'h0 - mag;
          r.res.value = mag;
        end
        held_count = 0;
      end
    end
    r.pending = held_count[2:0];
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    pending_rx.push_back(b);
    queued_total++;
  endtask

  // Queue one frame; an unknown code sends only the address and the code
  task automatic push_frame(input logic [7:0] addr, input logic [7:0] code,
                            input logic [7:0] lead, input logic [31:0] body,
                            input logic [7:0] tail);
    push_byte(addr);
    push_byte(code);
    case (code)
      CODE_VEL: begin
        push_byte(lead);
        push_byte(body[15:8]);
        push_byte(body[7:0]);
        push_byte(tail);
      end
      CODE_POS: begin
        push_byte(lead);
        push_byte(body[31:24]);
        push_byte(body[23:16]);
        push_byte(body[15:8]);
        push_byte(body[7:0]);
        push_byte(tail);
      end
      CODE_FLAG, CODE_IO: begin
        push_byte(lead);
        push_byte(tail);
      end
      default: ;
    endcase
  endtask

  // Mostly well-formed frames with random content, some noise and bad codes
  task automatic queue_random(input int unsigned count);
    int unsigned target;
    int unsigned roll;
    logic [7:0]  code;
    logic [7:0]  lead;
    logic [7:0]  tail;
    logic [31:0] body;
    target = queued_total + count;
    while (queued_total < target) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        push_byte(8'($urandom_range(255)));
      end else if (roll < 16) begin
        push_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 8'h00, 32'h0, 8'h00);
      end else begin
        case ($urandom_range(3))
          0:       code = CODE_VEL;
          1:       code = CODE_POS;
          2:       code = CODE_FLAG;
          default: code = CODE_IO;
        endcase
        case ($urandom_range(7))
          0:       body = 32'h0000_0000;
          1:       body = 32'hFFFF_FFFF;
          2:       body = 32'h8000_0000;
          default: body = $urandom();
        endcase
        lead = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
        tail = ($urandom_range(99) < 88) ? FRAME_END : 8'($urandom_range(255));
        push_frame(8'($urandom_range(255)), code, lead, body, tail);
      end
    end
  endtask

  // Hold until every queued byte has been taken and answered
  task automatic wait_drained();
    while (pending_rx.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatch_count++;
    end
  endtask

  // Offer bytes from the queue; record a prediction for each accepted item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_replies.push_back(predict_reply(rx_byte));
      if (!in_valid || !in_stall) begin
        if (pending_rx.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte  <= pending_rx.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side at random, with one long hold in the last phase
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (phase == 3 && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $error("result with no item waiting: addr %0h value %0h", responder_addr, reply_value);
        mismatch_count++;
      end else begin
        want = expected_replies.pop_front();
        check_field("frame_done", 32'(want.res.done), 32'(frame_done));
        check_field("frame_ok", 32'(want.res.ok), 32'(frame_ok));
        check_field("frame_dropped", 32'(want.res.dropped), 32'(frame_dropped));
        check_field("responder_addr", 32'(want.res.addr), 32'(responder_addr));
        check_field("reply_kind", 32'(want.res.kind), 32'(reply_kind));
        check_field("reply_value", want.res.value, reply_value);
        check_field("pending_bytes", 32'(want.pending), 32'(pending_bytes));
      end
    end
  end

  initial begin
    int unsigned phase_idx;
    send_idle_pct = 25;
    recv_idle_pct = 87;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every code, missing terminator, unknown code
    push_frame(8'h00, CODE_VEL, 8'h01, 32'h0000_FFFF, FRAME_END);
    push_frame(8'hFF, CODE_POS, 8'hFF, 32'h8000_0000, FRAME_END);
    push_frame(8'h12, CODE_FLAG, 8'hFF, 32'h0, FRAME_END);
    push_frame(8'h7E, CODE_IO, 8'h00, 32'h0, 8'h00);
    push_frame(8'h55, 8'h00, 8'h00, 32'h0, 8'h00);

    for (phase_idx = 1; phase_idx <= 3; phase_idx++) begin
      case (phase_idx)
        1: begin
          send_idle_pct = 25;
          recv_idle_pct = 87;
        end
        2: begin
          send_idle_pct = 87;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase = phase_idx;
      queue_random(PHASE_BYTES);
      // Pause the sender until every result of this phase is in
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_replies.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Stop a hung run
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== stepper_reply_deframer.f =====
rtl/core/sdf_pkg.sv
rtl/core/sdf_decode.sv
rtl/core/stepper_reply_deframer.sv
rtl/core/sdf_checker.sv
bench/testbench.sv
